// ===== hdl/rc4_keystream_cipher_defines.svh =====
// Assertion macros shared by the RC4 checker.
`ifndef RC4_KEYSTREAM_CIPHER_DEFINES_SVH
`define RC4_KEYSTREAM_CIPHER_DEFINES_SVH

// Antecedent at one edge, consequent at the next edge.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent at the same edge.
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rc4_pkg.sv =====
// Shared constants and controller/datapath interface types of the RC4 cipher.
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_CW = $clog2(MAX_KEY_BYTES + 1);

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  typedef struct packed {
    logic accept_key;   // store key byte, maybe start schedule
    logic accept_data;  // latch data byte, bump i, read S[i]
    logic data_rdj;     // bump j, read S[j]
    logic data_swap_i;  // write S[i], read S[t]
    logic data_swap_j;  // write S[j], form keystream
    logic out_load;     // load output register
    logic ksa_rd;       // read S[n] and key byte
    logic ksa_rdj;      // bump j, read S[j]
    logic ksa_wr_n;     // write S[n]
    logic ksa_wr_j;     // write S[j], advance n
  } rc4_cmd_t;

  typedef struct packed {
    logic ksa_last;     // current schedule step is the final one
    logic out_free;     // output register can take a result
  } rc4_sts_t;

endpackage

// ===== hdl/rc4_ctrl.sv =====
// Sequencing state machine of the RC4 cipher.
module rc4_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_req,
  input  logic            in_last,
  output logic            in_ready,
  output rc4_pkg::rc4_cmd_t cmd,
  input  rc4_pkg::rc4_sts_t sts
);
  import rc4_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D_RJ = 3'd1;
  localparam logic [2:0] ST_D_SW = 3'd2;
  localparam logic [2:0] ST_D_OUT = 3'd3;
  localparam logic [2:0] ST_K_RD = 3'd4;
  localparam logic [2:0] ST_K_RJ = 3'd5;
  localparam logic [2:0] ST_K_WN = 3'd6;
  localparam logic [2:0] ST_K_WJ = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req == REQ_DATA) begin
            cmd.accept_data = 1'b1;
            state_next = ST_D_RJ;
          end else begin
            cmd.accept_key = 1'b1;
            if (in_last) state_next = ST_K_RD;
          end
        end
      end
      ST_D_RJ: begin
        cmd.data_rdj = 1'b1;
        state_next = ST_D_SW;
      end
      ST_D_SW: begin
        cmd.data_swap_i = 1'b1;
        state_next = ST_D_OUT;
      end
      ST_D_OUT: begin
        // hold here until the output register frees up
        cmd.data_swap_j = 1'b1;
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_K_RD: begin
        cmd.ksa_rd = 1'b1;
        state_next = ST_K_RJ;
      end
      ST_K_RJ: begin
        cmd.ksa_rdj = 1'b1;
        state_next = ST_K_WN;
      end
      ST_K_WN: begin
        cmd.ksa_wr_n = 1'b1;
        state_next = ST_K_WJ;
      end
      ST_K_WJ: begin
        cmd.ksa_wr_j = 1'b1;
        state_next = sts.ksa_last ? ST_IDLE : ST_K_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/rc4_dp.sv =====
// Datapath of the RC4 cipher: permutation and key memories, indices, output register.
module rc4_dp (
  input  logic            clk,
  input  logic            rst,
  input  rc4_pkg::rc4_cmd_t cmd,
  output rc4_pkg::rc4_sts_t sts,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte
);
  import rc4_pkg::*;

  // permutation memory; an entry not written since the last reload reads as its address
  logic [7:0]   perm_mem [256];
  logic [255:0] perm_vld;
  logic [7:0]   perm_rd;
  logic         perm_rd_vld;
  logic [7:0]   perm_rd_addr;
  logic [7:0]   perm_q;

  logic         perm_re;
  logic [7:0]   perm_ra;
  logic         perm_we;
  logic [7:0]   perm_wa;
  logic [7:0]   perm_wd;

  logic [7:0]   key_mem [MAX_KEY_BYTES];
  logic [7:0]   key_q;

  logic [7:0]        idx_i;
  logic [7:0]        idx_j;
  logic [7:0]        j_next;
  logic [KEY_CW-1:0] key_fill;
  logic [KEY_CW-1:0] fill_inc;
  logic              fill_room;
  logic [KEY_CW-1:0] key_len;
  logic [KEY_AW-1:0] kidx;
  logic              kidx_wrap;

  logic [7:0] si_q;
  logic [7:0] sj_q;
  logic [7:0] t_q;
  logic [7:0] din_q;
  logic [7:0] ks;

  assign perm_q = perm_rd_vld ? perm_rd : perm_rd_addr;

  assign fill_room = (key_fill < KEY_CW'(MAX_KEY_BYTES));
  assign fill_inc = fill_room ? key_fill + KEY_CW'(1) : key_fill;
  assign kidx_wrap = ((KEY_CW'(kidx) + KEY_CW'(1)) == key_len);

  assign j_next = idx_j + perm_q + (cmd.ksa_rdj ? key_q : 8'd0);

  // later swap write wins when the keystream index hits a swapped entry
  assign ks = (t_q == idx_j) ? si_q :
              (t_q == idx_i) ? sj_q : perm_q;

  assign sts.ksa_last = (idx_i == 8'hFF);
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    perm_re = 1'b0;
    perm_ra = idx_i;
    perm_we = 1'b0;
    perm_wa = idx_i;
    perm_wd = perm_q;
    if (cmd.accept_data) begin
      perm_re = 1'b1;
      perm_ra = idx_i + 8'd1;
    end
    if (cmd.ksa_rd) begin
      perm_re = 1'b1;
      perm_ra = idx_i;
    end
    if (cmd.data_rdj || cmd.ksa_rdj) begin
      perm_re = 1'b1;
      perm_ra = j_next;
    end
    if (cmd.data_swap_i) begin
      perm_we = 1'b1;
      perm_wa = idx_i;
      perm_wd = perm_q;
      perm_re = 1'b1;
      perm_ra = si_q + perm_q;
    end
    if (cmd.ksa_wr_n) begin
      perm_we = 1'b1;
      perm_wa = idx_i;
      perm_wd = perm_q;
    end
    if (cmd.data_swap_j || cmd.ksa_wr_j) begin
      perm_we = 1'b1;
      perm_wa = idx_j;
      perm_wd = si_q;
    end
  end

  // read-first memory: a read in a write cycle returns the old contents
  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[perm_wa] <= perm_wd;
    if (perm_re) begin
      perm_rd      <= perm_mem[perm_ra];
      perm_rd_addr <= perm_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_vld    <= '0;
      perm_rd_vld <= 1'b0;
    end else begin
      if (perm_re) perm_rd_vld <= perm_vld[perm_ra];
      if (cmd.accept_key && in_last) begin
        perm_vld <= '0;
      end else if (perm_we) begin
        perm_vld[perm_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_key && fill_room) key_mem[key_fill[KEY_AW-1:0]] <= in_byte;
    if (cmd.ksa_rd) key_q <= key_mem[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i     <= '0;
      idx_j     <= '0;
      key_fill  <= '0;
      key_len   <= '0;
      kidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept_key) begin
        key_fill <= in_last ? '0 : fill_inc;
        if (in_last) begin
          key_len <= fill_inc;
          idx_i   <= '0;
          idx_j   <= '0;
          kidx    <= '0;
        end
      end
      if (cmd.accept_data) idx_i <= idx_i + 8'd1;
      if (cmd.data_rdj || cmd.ksa_rdj) idx_j <= j_next;
      if (cmd.ksa_wr_j) begin
        idx_i <= idx_i + 8'd1;
        kidx  <= kidx_wrap ? '0 : kidx + KEY_AW'(1);
        if (sts.ksa_last) idx_j <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_data) din_q <= in_byte;
    if (cmd.data_rdj || cmd.ksa_rdj) si_q <= perm_q;
    if (cmd.data_swap_i) begin
      sj_q <= perm_q;
      t_q  <= si_q + perm_q;
    end
    if (cmd.out_load) out_byte <= din_q ^ ks;
  end

endmodule

// ===== hdl/rc4_keystream_cipher.sv =====
// Top level of the RC4 stream cipher: controller plus datapath.
// RC4 (ARCFOUR) stream cipher. Feed key bytes with tuser = 0, one per
// transaction, and mark the final key byte with tlast; that transaction
// fixes the key length, rebuilds the permutation and runs the 256-step key
// schedule. Key bytes past 256 are dropped, and a key transaction returns no
// result. Feed data bytes with tuser = 1; each returns one byte, the input
// XORed with the next keystream byte, on the master side in the same order.
// Data sent before any key is enciphered with the identity permutation.
// Every schedule step makes two reads and two writes through the single
// write port of the permutation memory. A data byte reads S[i], S[j] and
// S[S[i]+S[j]] in turn, each through the registered read port, and waits
// while a finished result still sits in the output register. Input is not
// taken during the schedule or while a data byte is in work.
module rc4_keystream_cipher (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic [0:0] s_tuser,   // [0] req_type: 0 key byte, 1 data byte
  input  logic       s_tlast,   // last_key
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [7:0] out_byte
);
  import rc4_pkg::*;

  rc4_cmd_t cmd;
  rc4_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser[0]),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rc4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata)
  );

endmodule

// ===== hdl/rc4_chk.sv =====
// Port-level checker for the RC4 cipher, bound to the top level.
`include "rc4_keystream_cipher_defines.svh"

module rc4_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [0:0] s_tuser,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import rc4_pkg::*;

  logic key_acc;
  logic data_acc;

  assign key_acc  = s_tvalid && s_tready && (s_tuser[0] == REQ_KEY);
  assign data_acc = s_tvalid && s_tready && (s_tuser[0] == REQ_DATA);

  `RC4_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `RC4_ASSERT_NEXT(a_key_ready, key_acc && !s_tlast, s_tready, "key byte did not free input")
  `RC4_ASSERT_NEXT(a_sched_busy, key_acc && s_tlast, !s_tready, "schedule did not block input")
  `RC4_ASSERT_NEXT(a_data_busy, data_acc, !s_tready, "data byte did not block input")

endmodule

bind rc4_keystream_cipher rc4_chk u_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the RC4 keystream cipher stream block.
`timescale 1ns / 100ps

module testbench;
  import rc4_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int LONG_HOLD   = 300;
  // Even one key schedule per sequence and the longest gaps and stalls on
  // every transaction stay far below this.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 1100;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;    // [7:0] in_byte
  logic [0:0] s_tuser = '0;    // [0] req_type
  logic       s_tlast = 1'b0;  // last_key
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;         // [7:0] out_byte

  always #5 clk = ~clk;

  rc4_keystream_cipher DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Cipher state mirror: permutation, key store, fill count and indices.
  logic [7:0] perm_mirror [256];
  logic [7:0] key_mirror [MAX_KEY_BYTES];
  int         key_fill_count;
  logic [8:0] key_len_mirror;
  logic [7:0] stream_i, stream_j;

  logic [7:0] pending_out_bytes [$];

  int  fail_count     = 0;
  int  checked_count  = 0;
  int  key_items      = 0;
  int  data_items     = 0;
  int  schedule_count = 0;
  int  dropped_keys   = 0;
  int  longest_key    = 0;
  int  cycle_count    = 0;
  int  burst_left     = 0;
  bit  hold_off_req   = 1'b0;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       last;
    logic       typed;   // out is given by hand
    logic [7:0] out;
  } stim_row_t;

  // Directed rows: data on the reset state (values read off the identity
  // permutation), a last-key mark on data, one-byte keys of all zeros and all
  // ones, a short key, a new key restarting the store, byte extremes.
  stim_row_t directed_rows [24] = '{
    '{REQ_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
    '{REQ_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA},
    '{REQ_DATA, 8'h5A, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
    '{REQ_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'h01, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'h80, 1'b1, 1'b0, 8'h00},
    '{REQ_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{REQ_DATA, 8'h3C, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'h4B, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'h65, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'h79, 1'b1, 1'b0, 8'h00},
    '{REQ_DATA, 8'h50, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'h6C, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'h61, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'h69, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'h6E, 1'b0, 1'b0, 8'h00},
    '{REQ_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},
    '{REQ_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_DATA, 8'h80, 1'b0, 1'b0, 8'h00}
  };

  function automatic void load_identity_perm();
    for (int n = 0; n < 256; n++) perm_mirror[n] = 8'(n);
  endfunction

  // Advance the cipher mirror by one transaction; return 1 with the
  // enciphered byte for a data transaction.
  function automatic bit rc4_advance(input logic req, input logic [7:0] b,
                                     input logic last, output logic [7:0] enc);
    logic [7:0] j;
    logic [7:0] tmp;
    logic [7:0] t;
    int         len;
    enc = '0;
    if (req == REQ_KEY) begin
      if (key_fill_count < MAX_KEY_BYTES) begin
        key_mirror[key_fill_count] = b;
        key_fill_count++;
      end else begin
        dropped_keys++;
      end
      if (last) begin
        key_len_mirror = 9'(key_fill_count);
        len = key_len_mirror;
        if (len > longest_key) longest_key = len;
        load_identity_perm();
        j = '0;
        for (int n = 0; n < 256; n++) begin
          j = j + perm_mirror[n] + key_mirror[n % len];
          tmp = perm_mirror[n];
          perm_mirror[n] = perm_mirror[j];
          perm_mirror[j] = tmp;
        end
        stream_i = '0;
        stream_j = '0;
        key_fill_count = 0;
        schedule_count++;
      end
      return 1'b0;
    end
    stream_i = stream_i + 8'd1;
    stream_j = stream_j + perm_mirror[stream_i];
    tmp = perm_mirror[stream_i];
    perm_mirror[stream_i] = perm_mirror[stream_j];
    perm_mirror[stream_j] = tmp;
    t = perm_mirror[stream_i] + perm_mirror[stream_j];
    enc = b ^ perm_mirror[t];
    return 1'b1;
  endfunction

  // Present one transaction and hold it until accepted, then predict.
  task automatic offer(input logic req, input logic [7:0] b, input logic last,
                       input bit typed, input logic [7:0] typed_out);
    logic [7:0] predicted;
    bit         emits;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    emits = rc4_advance(req, b, last, predicted);
    if (emits) pending_out_bytes.push_back(typed ? typed_out : predicted);
    if (req == REQ_KEY) key_items++;
    else data_items++;
  endtask

  // Keep the burst going, or drop valid for a random gap; with drain set,
  // hold off until every expected byte has come back.
  task automatic pace(input bit drain);
    int gap;
    if (!drain && burst_left > 0) begin
      burst_left--;
      return;
    end
    s_tvalid <= 1'b0;
    if (drain) begin
      do @(posedge clk); while (pending_out_bytes.size() != 0);
    end else begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(0, 15);
  endtask

  // One random sequence: mostly a key followed by a data run, sometimes a
  // data run on the running stream, sometimes stray transactions.
  task automatic send_sequence(input int seq);
    int kind;
    int key_len;
    int n_data;
    kind = $urandom_range(0, 9);
    // Sequences 3 and 6 carry the long output stall and the drain pause.
    if (seq > 1 && seq != 3 && seq != 6 && kind < 2) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0:       offer(REQ_DATA, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
          1:       offer(REQ_KEY,  8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
          2:       offer(REQ_KEY,  8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
          default: offer(REQ_DATA, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        endcase
        pace(1'b0);
      end
      return;
    end
    if (kind != 2 || seq <= 1) begin
      // Overfill the key store first, then fill it exactly.
      if (seq == 0) key_len = MAX_KEY_BYTES + 4;
      else if (seq == 1) key_len = MAX_KEY_BYTES;
      else if ($urandom_range(0, 29) == 0)
        key_len = $urandom_range(MAX_KEY_BYTES - 8, MAX_KEY_BYTES + 8);
      else key_len = $urandom_range(1, 16);
      for (int k = 0; k < key_len; k++) begin
        offer(REQ_KEY, 8'($urandom_range(0, 255)), k == key_len - 1, 1'b0, '0);
        pace(1'b0);
      end
    end
    // Stall the output for a long stretch while data keeps coming.
    if (seq == 3) hold_off_req = 1'b1;
    n_data = $urandom_range(4, 40);
    for (int k = 0; k < n_data; k++) begin
      offer(REQ_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
            1'b0, '0);
      pace(seq == 6 && k == n_data - 1);
    end
  endtask

  initial begin : stimulus
    int seq;
    load_identity_perm();
    for (int n = 0; n < MAX_KEY_BYTES; n++) key_mirror[n] = '0;
    key_fill_count = 0;
    key_len_mirror = '0;
    stream_i = '0;
    stream_j = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      offer(directed_rows[r].req, directed_rows[r].data, directed_rows[r].last,
            directed_rows[r].typed, directed_rows[r].out);
      pace(1'b0);
    end

    seq = 0;
    while (key_items + data_items < ITEM_TARGET) begin
      send_sequence(seq);
      seq++;
    end

    // Wait for the last results, then let a trailing schedule finish.
    pace(1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_out_bytes.size() != 0) begin
      $error("%0d expected out_byte values never arrived", pending_out_bytes.size());
      fail_count++;
    end

    $display("Run covered %0d key and %0d data transactions, %0d key schedules, %0d",
             key_items, data_items, schedule_count, dropped_keys);
    $display("key bytes dropped on a full store, longest key %0d, %0d outputs checked",
             longest_key, checked_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Output side: change the stall pattern every so often; on request hold
  // tready low for a long stretch.
  initial begin : downstream_pattern
    int mode;
    int mode_left;
    int phase;
    mode = 0;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        continue;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= (phase % 4 == 0);
        default: m_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : out_check
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_out_bytes.size() == 0) begin
        $error("out_byte: no result expected, got %02h", m_tdata);
        fail_count++;
      end else begin
        want = pending_out_bytes.pop_front();
        checked_count++;
        if (m_tdata !== want) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want, m_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== rc4_keystream_cipher.f =====
+incdir+hdl
hdl/rc4_pkg.sv
hdl/rc4_ctrl.sv
hdl/rc4_dp.sv
hdl/rc4_keystream_cipher.sv
hdl/rc4_chk.sv
tb/testbench.sv
